// ----- src/jac_pkg.sv -----
// shared types and constants of the joystick axis conditioner
// no dependencies; imported by jac_div, joystick_axis_conditioner and the testbench
package jac_pkg;

    localparam int SAMPLE_BITS_DEF = 10;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 10;
    localparam int PCT_W           = 8;
    localparam int PCT_MAG_W       = 7;
    localparam int SCALE_EXTRA_W   = 7;

    localparam int CENTRE_RST = 400;
    localparam int UPPER_RST  = 600;
    localparam int LOWER_RST  = 200;

    localparam logic [9:0] CALIB_SPAN_RST = 10'd200;
    localparam logic [7:0] TOLERANCE_RST  = 8'd10;
    localparam logic [6:0] DEAD_ZONE_RST  = 7'd5;
    localparam logic [7:0] THRESHOLD_RST  = 8'd25;
    localparam logic [9:0] DPAD_HIGH_RST  = 10'd650;
    localparam logic [9:0] DPAD_LOW_RST   = 10'd300;

    localparam logic [PCT_MAG_W-1:0] PCT_LIMIT  = 7'd100;
    localparam logic [PCT_MAG_W-1:0] QUOT_LIMIT = 7'd127;
    localparam logic [14:0]          DIV10_MUL  = 15'd205;
    localparam int                   DIV10_SHIFT = 11;

    typedef enum logic [1:0] {
        ACT_RECAL  = 2'd0,
        ACT_READ_X = 2'd1,
        ACT_READ_Y = 2'd2,
        ACT_DPAD   = 2'd3
    } action_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CALIB_SPAN = 3'd0,
        CFG_TOLERANCE  = 3'd1,
        CFG_DEAD_ZONE  = 3'd2,
        CFG_THRESHOLD  = 3'd3,
        CFG_DPAD_HIGH  = 3'd4,
        CFG_DPAD_LOW   = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_PREP   = 3'd1,
        ST_SCALE  = 3'd2,
        ST_DIV    = 3'd3,
        ST_HOLD   = 3'd4,
        ST_ROUND  = 3'd5,
        ST_FINISH = 3'd6
    } state_t;

endpackage

// ----- src/jac_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
// depends on jac_pkg for house conventions only
module jac_div #(
    parameter int NUM_W = jac_pkg::SAMPLE_BITS_DEF + jac_pkg::SCALE_EXTRA_W,
    parameter int DEN_W = jac_pkg::SAMPLE_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    import jac_pkg::*;

    localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W+1:0] diff;
    logic             ge;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, den_reg};
    assign ge    = !diff[DEN_W+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W - 1);
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider did not start");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");
    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !start && cnt_reg == '0 |=> done_reg)
        else $error("divider missed its last step");
`endif

endmodule

// ----- src/joystick_axis_conditioner.sv -----
// top level of the joystick axis conditioner: calibration state, config, control
// depends on jac_pkg and jac_div
//
// usage:
//   input channel (in_valid/in_ready) moves one transfer per item: action,
//   sample_x, sample_y. output channel (out_valid/out_ready) returns one
//   result per item: axis_percent and the four d-pad bits.
//   config channel (cfg_valid/cfg_ready) writes one register per transfer;
//   cfg_ready is always high; write only while the block is idle.
// sequence:
//   recalibrate and d-pad items pass through ST_PREP and ST_FINISH before the next accept;
//   the result is loaded into the output register from ST_FINISH.
//   axis reads pass through ST_PREP, ST_SCALE, ST_DIV, ST_HOLD, ST_ROUND and
//   ST_FINISH; in ST_DIV the restoring divider produces one quotient bit per
//   cycle and the state waits for its done.
//   one item is in flight at a time.
// reset: centres 400, bounds 200/600, held values 0, registers at defaults.
// stall: a finished result waits in the output register; the next item is
//   accepted meanwhile and its result waits until the register is taken.
module joystick_axis_conditioner #(
    parameter int SAMPLE_BITS = jac_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       action,
    input  logic [SAMPLE_BITS-1:0]           sample_x,
    input  logic [SAMPLE_BITS-1:0]           sample_y,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [jac_pkg::PCT_W-1:0] axis_percent,
    output logic                             dir_left,
    output logic                             dir_right,
    output logic                             dpad_up,
    output logic                             dir_down,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [jac_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [jac_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import jac_pkg::*;

    localparam int W     = SAMPLE_BITS;
    localparam int CW    = ((W > CFG_DATA_W) ? W : CFG_DATA_W) + 1;
    localparam int NUM_W = W + SCALE_EXTRA_W;
    localparam logic [W-1:0] SAMPLE_MAX = '1;

    function automatic logic [W-1:0] recal_hi(logic [W-1:0] c, logic [9:0] s);
        logic [CW-1:0] sum;
        sum = CW'(c) + CW'(s);
        return (sum > CW'(SAMPLE_MAX)) ? SAMPLE_MAX : sum[W-1:0];
    endfunction

    function automatic logic [W-1:0] recal_lo(logic [W-1:0] c, logic [9:0] s);
        logic [CW-1:0] dif;
        dif = CW'(c) - CW'(s);
        return (CW'(c) > CW'(s)) ? dif[W-1:0] : '0;
    endfunction

    state_t state_reg, state_next;
    action_t action_reg;
    logic [W-1:0] sx_reg, sy_reg;

    logic [9:0] span_reg;
    logic [7:0] tol_reg;
    logic [6:0] dz_reg;
    logic [7:0] thr_reg;
    logic [9:0] dhi_reg;
    logic [9:0] dlo_reg;

    logic [W-1:0] centre_x_reg, centre_x_next, centre_y_reg, centre_y_next;
    logic [W-1:0] upper_x_reg, upper_x_next, lower_x_reg, lower_x_next;
    logic [W-1:0] upper_y_reg, upper_y_next, lower_y_reg, lower_y_next;
    logic signed [PCT_W-1:0] held_x_reg, held_x_next, held_y_reg, held_y_next;

    logic [W-1:0] off_reg, off_next;
    logic pos_reg, pos_next, neg_reg, neg_next;
    logic qneg_reg, qneg_next, dzero_reg, dzero_next;
    logic signed [PCT_W-1:0] r_reg, r_next, v_reg, v_next, pct_reg, pct_next;
    logic [3:0] dpad_reg, dpad_next;

    logic out_valid_reg, out_valid_next;
    logic signed [PCT_W-1:0] axis_percent_reg;
    logic [3:0] dpad_out_reg;
    logic out_load;

    logic sel_y, is_x;
    logic [W-1:0] cur, cen, upp, low;
    logic [CW-1:0] cur_ext, tol_ext, lo_sum;
    logic [W-1:0] up_tol, lo_tol;

    logic [NUM_W-1:0] num100;
    logic signed [W:0] den_s;
    logic [W-1:0] den_mag;
    logic div_start, div_done;
    logic [NUM_W-1:0] div_quot;

    logic [PCT_MAG_W-1:0] q7, qm;
    logic [PCT_W-1:0] r_pos;
    logic signed [PCT_W-1:0] held_sel;
    logic signed [PCT_W:0] dlt;
    logic [PCT_W:0] dlt_abs;
    logic exceed;

    logic [PCT_W-1:0] v_abs;
    logic [PCT_MAG_W-1:0] v_clamp, res;
    logic [14:0] prod;
    logic [3:0] tens;

    assign sel_y = (action_reg == ACT_READ_Y);
    assign is_x  = (action_reg == ACT_READ_X);
    assign cur   = sel_y ? sy_reg : sx_reg;
    assign cen   = sel_y ? centre_y_reg : centre_x_reg;
    assign upp   = sel_y ? upper_y_reg : upper_x_reg;
    assign low   = sel_y ? lower_y_reg : lower_x_reg;

    // bound tracking with tolerance pull-back
    assign cur_ext = CW'(cur);
    assign tol_ext = CW'(tol_reg);
    assign lo_sum  = cur_ext + tol_ext;
    assign up_tol  = (cur > upp)
                   ? ((cur_ext > tol_ext) ? W'(cur_ext - tol_ext) : '0) : upp;
    assign lo_tol  = (cur < low)
                   ? ((lo_sum > CW'(SAMPLE_MAX)) ? SAMPLE_MAX : lo_sum[W-1:0]) : low;

    // offset times 100 as shifted adds
    assign num100 = (NUM_W'(off_reg) << 6) + (NUM_W'(off_reg) << 5)
                  + (NUM_W'(off_reg) << 2);
    assign den_s  = pos_reg ? ($signed({1'b0, upp}) - $signed({1'b0, cen}))
                            : ($signed({1'b0, cen}) - $signed({1'b0, low}));
    assign den_mag = den_s[W] ? W'(-den_s) : den_s[W-1:0];

    jac_div #(
        .NUM_W (NUM_W),
        .DEN_W (W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num100),
        .den   (den_mag),
        .done  (div_done),
        .quot  (div_quot)
    );

    // saturation and dead zone
    assign q7    = (|div_quot[NUM_W-1:PCT_MAG_W]) ? QUOT_LIMIT : div_quot[PCT_MAG_W-1:0];
    assign qm    = (dzero_reg || q7 < dz_reg) ? '0 : q7;
    assign r_pos = {1'b0, qm};

    // change threshold with hold
    assign held_sel = sel_y ? held_y_reg : held_x_reg;
    assign dlt      = {r_reg[PCT_W-1], r_reg} - {held_sel[PCT_W-1], held_sel};
    assign dlt_abs  = dlt[PCT_W] ? (PCT_W + 1)'(-dlt) : dlt;
    assign exceed   = dlt_abs > {1'b0, thr_reg};

    // clamp and truncate to tens
    assign v_abs   = v_reg[PCT_W-1] ? PCT_W'(-v_reg) : v_reg;
    assign v_clamp = (v_abs[PCT_MAG_W-1:0] > PCT_LIMIT) ? PCT_LIMIT : v_abs[PCT_MAG_W-1:0];
    assign prod    = 15'(v_clamp) * DIV10_MUL;
    assign tens    = 4'(prod >> DIV10_SHIFT);
    assign res     = PCT_MAG_W'({tens, 3'b000}) + PCT_MAG_W'({tens, 1'b0});

    always_comb
    begin
        state_next     = state_reg;
        centre_x_next  = centre_x_reg;
        centre_y_next  = centre_y_reg;
        upper_x_next   = upper_x_reg;
        lower_x_next   = lower_x_reg;
        upper_y_next   = upper_y_reg;
        lower_y_next   = lower_y_reg;
        held_x_next    = held_x_reg;
        held_y_next    = held_y_reg;
        off_next       = off_reg;
        pos_next       = pos_reg;
        neg_next       = neg_reg;
        qneg_next      = qneg_reg;
        dzero_next     = dzero_reg;
        r_next         = r_reg;
        v_next         = v_reg;
        pct_next       = pct_reg;
        dpad_next      = dpad_reg;
        div_start      = 1'b0;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                unique case (action_reg)
                    ACT_RECAL:
                    begin
                        centre_x_next = sx_reg;
                        upper_x_next  = recal_hi(sx_reg, span_reg);
                        lower_x_next  = recal_lo(sx_reg, span_reg);
                        centre_y_next = sy_reg;
                        upper_y_next  = recal_hi(sy_reg, span_reg);
                        lower_y_next  = recal_lo(sy_reg, span_reg);
                        pct_next      = '0;
                        dpad_next     = '0;
                        state_next    = ST_FINISH;
                    end
                    ACT_DPAD:
                    begin
                        upper_x_next = (sx_reg > upper_x_reg) ? sx_reg : upper_x_reg;
                        lower_x_next = (sx_reg < lower_x_reg) ? sx_reg : lower_x_reg;
                        upper_y_next = (sy_reg > upper_y_reg) ? sy_reg : upper_y_reg;
                        lower_y_next = (sy_reg < lower_y_reg) ? sy_reg : lower_y_reg;
                        // order: left, right, up, down
                        dpad_next[3] = CW'(sx_reg) > CW'(dhi_reg);
                        dpad_next[2] = CW'(sx_reg) < CW'(dlo_reg);
                        dpad_next[1] = CW'(sy_reg) < CW'(dlo_reg);
                        dpad_next[0] = CW'(sy_reg) > CW'(dhi_reg);
                        pct_next     = '0;
                        state_next   = ST_FINISH;
                    end
                    ACT_READ_X, ACT_READ_Y:
                    begin
                        if (sel_y)
                        begin
                            upper_y_next = up_tol;
                            lower_y_next = lo_tol;
                        end
                        else
                        begin
                            upper_x_next = up_tol;
                            lower_x_next = lo_tol;
                        end
                        off_next   = (cur >= cen) ? cur - cen : cen - cur;
                        pos_next   = cur > cen;
                        neg_next   = cur < cen;
                        state_next = ST_SCALE;
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_SCALE:
            begin
                qneg_next  = neg_reg ^ den_s[W];
                dzero_next = (den_s == '0);
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    r_next     = qneg_reg ? PCT_W'(-r_pos) : r_pos;
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (exceed)
                begin
                    v_next = r_reg;
                    if (sel_y)
                        held_y_next = r_reg;
                    else
                        held_x_next = r_reg;
                end
                else
                begin
                    v_next = held_sel;
                end
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                // x axis reported with inverted sign
                pct_next   = (v_reg[PCT_W-1] ^ is_x) ? PCT_W'(-{1'b0, res})
                                                     : {1'b0, res};
                dpad_next  = '0;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            centre_x_reg  <= W'(CENTRE_RST);
            centre_y_reg  <= W'(CENTRE_RST);
            upper_x_reg   <= W'(UPPER_RST);
            lower_x_reg   <= W'(LOWER_RST);
            upper_y_reg   <= W'(UPPER_RST);
            lower_y_reg   <= W'(LOWER_RST);
            held_x_reg    <= '0;
            held_y_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            centre_x_reg  <= centre_x_next;
            centre_y_reg  <= centre_y_next;
            upper_x_reg   <= upper_x_next;
            lower_x_reg   <= lower_x_next;
            upper_y_reg   <= upper_y_next;
            lower_y_reg   <= lower_y_next;
            held_x_reg    <= held_x_next;
            held_y_reg    <= held_y_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_reg <= CALIB_SPAN_RST;
            tol_reg  <= TOLERANCE_RST;
            dz_reg   <= DEAD_ZONE_RST;
            thr_reg  <= THRESHOLD_RST;
            dhi_reg  <= DPAD_HIGH_RST;
            dlo_reg  <= DPAD_LOW_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_CALIB_SPAN: span_reg <= cfg_data[9:0];
                CFG_TOLERANCE:  tol_reg  <= cfg_data[7:0];
                CFG_DEAD_ZONE:  dz_reg   <= cfg_data[6:0];
                CFG_THRESHOLD:  thr_reg  <= cfg_data[7:0];
                CFG_DPAD_HIGH:  dhi_reg  <= cfg_data[9:0];
                CFG_DPAD_LOW:   dlo_reg  <= cfg_data[9:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            action_reg <= action_t'(action);
            sx_reg     <= sample_x;
            sy_reg     <= sample_y;
        end
        off_reg   <= off_next;
        pos_reg   <= pos_next;
        neg_reg   <= neg_next;
        qneg_reg  <= qneg_next;
        dzero_reg <= dzero_next;
        r_reg     <= r_next;
        v_reg     <= v_next;
        pct_reg   <= pct_next;
        dpad_reg  <= dpad_next;
        if (out_load)
        begin
            axis_percent_reg <= pct_reg;
            dpad_out_reg     <= dpad_reg;
        end
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign axis_percent = axis_percent_reg;
    assign dir_left     = dpad_out_reg[3];
    assign dir_right    = dpad_out_reg[2];
    assign dpad_up      = dpad_out_reg[1];
    assign dir_down     = dpad_out_reg[0];

`ifndef SYNTHESIS
    a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_PREP)
        else $error("transfer accepted but item not started");
    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_x_reg != 8'sh80 && held_y_reg != 8'sh80)
        else $error("held value out of range");
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> axis_percent_reg <= 8'sd100 && axis_percent_reg >= -8'sd100)
        else $error("axis percent out of range");
    a_dpad_no_pct: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (|dpad_out_reg) |-> axis_percent_reg == '0)
        else $error("d-pad result carries axis value");
`endif

endmodule

// ----- verif/joystick_axis_conditioner_tb.sv -----
// testbench for joystick_axis_conditioner: directed and random items with an in-line predictor
// of centres, tracked bounds, held percentages and d-pad thresholds, register writes between
// phases and random idling on both channels; depends on jac_pkg and the rtl only
module joystick_axis_conditioner_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jac_pkg::*;

    localparam int     SAMPLE_MAX   = 1023;
    localparam int     SETTLE_LIMIT = 5000;
    localparam int     DRAIN_CYCLES = 30;
    localparam int     HOLD_CYCLES  = 300;
    localparam int     RANDOM_ITEMS = 320;
    localparam longint RUN_LIMIT_NS = 64'd12_000_000;

    typedef struct packed {
        logic signed [7:0] pct;
        logic              left;
        logic              right;
        logic              up;
        logic              down;
    } joy_result_t;

    class joystick_results;
        int span, tolerance, dead_zone, threshold, dpad_hi, dpad_lo;
        int centre[2], upper[2], lower[2], held[2];
        joy_result_t pending_results[$];
        int failures;
        int checked;
        int action_count[4];

        function new();
            span      = 200;
            tolerance = 10;
            dead_zone = 5;
            threshold = 25;
            dpad_hi   = 650;
            dpad_lo   = 300;
            for (int ax = 0; ax < 2; ax++)
            begin
                centre[ax] = 400;
                upper[ax]  = 600;
                lower[ax]  = 200;
                held[ax]   = 0;
            end
            failures = 0;
            checked  = 0;
            for (int a = 0; a < 4; a++)
                action_count[a] = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, int value);
            case (idx)
                CFG_CALIB_SPAN: span      = value & 'h3ff;
                CFG_TOLERANCE:  tolerance = value & 'hff;
                CFG_DEAD_ZONE:  dead_zone = value & 'h7f;
                CFG_THRESHOLD:  threshold = value & 'hff;
                CFG_DPAD_HIGH:  dpad_hi   = value & 'h3ff;
                CFG_DPAD_LOW:   dpad_lo   = value & 'h3ff;
                default: ;
            endcase
        endfunction

        // widen with pull-back, scale, saturate, dead zone, hold, clamp, tens
        function int condition_axis(int ax, int cur);
            int num;
            int den;
            int q;
            int diff;
            if (cur > upper[ax])
                upper[ax] = (cur > tolerance) ? cur - tolerance : 0;
            if (cur < lower[ax])
                lower[ax] = (cur + tolerance > SAMPLE_MAX) ? SAMPLE_MAX : cur + tolerance;
            num = (cur - centre[ax]) * 100;
            den = (cur > centre[ax]) ? upper[ax] - centre[ax] : centre[ax] - lower[ax];
            q = (den == 0) ? 0 : num / den;
            if (q > 127)
                q = 127;
            if (q < -127)
                q = -127;
            if ((q < 0 ? -q : q) < dead_zone)
                q = 0;
            diff = q - held[ax];
            if (diff < 0)
                diff = -diff;
            if (diff > threshold)
                held[ax] = q;
            else
                q = held[ax];
            if (q > 100)
                q = 100;
            if (q < -100)
                q = -100;
            return (q / 10) * 10;
        endfunction

        function void note_item(action_t act, int sx, int sy);
            joy_result_t r;
            int cur;
            r = '0;
            action_count[int'(act)]++;
            case (act)
                ACT_RECAL:
                begin
                    for (int ax = 0; ax < 2; ax++)
                    begin
                        cur = ax ? sy : sx;
                        centre[ax] = cur;
                        upper[ax]  = (cur + span > SAMPLE_MAX) ? SAMPLE_MAX : cur + span;
                        lower[ax]  = (cur > span) ? cur - span : 0;
                    end
                end
                ACT_READ_X: r.pct = 8'(-condition_axis(0, sx));
                ACT_READ_Y: r.pct = 8'(condition_axis(1, sy));
                default:
                begin
                    for (int ax = 0; ax < 2; ax++)
                    begin
                        cur = ax ? sy : sx;
                        if (cur > upper[ax])
                            upper[ax] = cur;
                        if (cur < lower[ax])
                            lower[ax] = cur;
                    end
                    r.left  = sx > dpad_hi;
                    r.right = sx < dpad_lo;
                    r.up    = sy < dpad_lo;
                    r.down  = sy > dpad_hi;
                end
            endcase
            pending_results.push_back(r);
        endfunction

        function void check_result(joy_result_t got);
            joy_result_t want;
            if (pending_results.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: result with nothing pending: pct %0d dpad %b%b%b%b", $time,
                             got.pct, got.left, got.right, got.up, got.down);
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (got.pct !== want.pct || got.left !== want.left || got.right !== want.right ||
                got.up !== want.up || got.down !== want.down)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: mismatch pct %0d/%0d left %b/%b right %b/%b up %b/%b down %b/%b",
                             $time, want.pct, got.pct, want.left, got.left, want.right, got.right,
                             want.up, got.up, want.down, got.down);
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    action_t              action;
    logic [9:0]           sample_x;
    logic [9:0]           sample_y;
    logic                 out_valid;
    logic                 out_ready;
    logic signed [7:0]    axis_percent;
    logic                 dir_left;
    logic                 dir_right;
    logic                 dpad_up;
    logic                 dir_down;
    logic                 cfg_valid;
    logic                 cfg_ready;
    cfg_reg_t             cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    joystick_results results;
    int idle_pct;
    int stall_pct;
    int hold_requests;
    int settings;

    joystick_axis_conditioner dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .sample_x     (sample_x),
        .sample_y     (sample_y),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .axis_percent (axis_percent),
        .dir_left     (dir_left),
        .dir_right    (dir_right),
        .dpad_up      (dpad_up),
        .dir_down     (dir_down),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                results.note_item(action, sample_x, sample_y);
            if (out_valid && out_ready)
                results.check_result('{pct: axis_percent, left: dir_left, right: dir_right,
                                       up: dpad_up, down: dir_down});
        end
    end

    // receiver: random stalls plus long hold-offs on request
    initial
    begin
        int hold_left;
        int holds_seen;
        hold_left  = 0;
        holds_seen = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_seen != hold_requests)
            begin
                holds_seen = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_item(action_t act, int sx, int sy);
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        sample_x <= 10'(sx);
        sample_y <= 10'(sy);
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic cfg_write(cfg_reg_t idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        results.write_reg(idx, value);
    endtask

    task automatic program_regs(int span, int tol, int dz, int thr, int hi, int lo);
        cfg_write(CFG_CALIB_SPAN, span);
        cfg_write(CFG_TOLERANCE, tol);
        cfg_write(CFG_DEAD_ZONE, dz);
        cfg_write(CFG_THRESHOLD, thr);
        cfg_write(CFG_DPAD_HIGH, hi);
        cfg_write(CFG_DPAD_LOW, lo);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic settle();
        int n;
        in_valid <= 1'b0;
        n = 0;
        @(posedge clk);
        while (results.pending_results.size() != 0 && n < SETTLE_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // samples near the centre, at the rails, or anywhere
    function automatic int pick_sample(int c);
        int v;
        case ($urandom_range(3))
            0: v = $urandom_range(SAMPLE_MAX);
            1: v = c + int'($urandom_range(80)) - 40;
            2: v = $urandom_range(1) ? int'($urandom_range(SAMPLE_MAX, 990)) :
                                       int'($urandom_range(33));
            default: v = c + int'($urandom_range(400)) - 200;
        endcase
        if (v < 0)
            v = 0;
        if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
        return v;
    endfunction

    task automatic run_random(int count);
        int pick;
        action_t act;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            act = (pick < 15) ? ACT_RECAL : (pick < 45) ? ACT_READ_X :
                  (pick < 75) ? ACT_READ_Y : ACT_DPAD;
            send_item(act, pick_sample(results.centre[0]), pick_sample(results.centre[1]));
        end
    endtask

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        results       = new();
        idle_pct      = 0;
        stall_pct     = 0;
        hold_requests = 0;
        settings      = 1;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        action    <= ACT_RECAL;
        sample_x  <= '0;
        sample_y  <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_CALIB_SPAN;
        cfg_data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: rails, centre, d-pad edges, saturated recalibration, zero divisor
        send_item(ACT_READ_X, 400, 400);
        send_item(ACT_READ_X, 1023, 0);
        send_item(ACT_READ_X, 0, 1023);
        send_item(ACT_READ_Y, 0, 1023);
        send_item(ACT_READ_Y, 1023, 0);
        send_item(ACT_DPAD, 651, 299);
        send_item(ACT_DPAD, 650, 300);
        send_item(ACT_DPAD, 299, 651);
        send_item(ACT_DPAD, 0, 1023);
        send_item(ACT_RECAL, 0, 1023);
        send_item(ACT_READ_X, 0, 512);
        send_item(ACT_READ_Y, 512, 1023);
        send_item(ACT_READ_Y, 0, 0);
        send_item(ACT_RECAL, 1023, 0);
        send_item(ACT_READ_X, 1023, 0);
        send_item(ACT_RECAL, 512, 512);
        send_item(ACT_READ_X, 520, 0);
        send_item(ACT_READ_X, 560, 0);
        send_item(ACT_READ_Y, 0, 700);
        send_item(ACT_READ_Y, 0, 300);
        run_random(RANDOM_ITEMS);
        settle();

        for (int ph = 1; ph < 6; ph++)
        begin
            case (ph)
                1:
                begin
                    program_regs($urandom_range(1023, 1), $urandom_range(255),
                                 $urandom_range(100), $urandom_range(200),
                                 $urandom_range(1023), $urandom_range(1023));
                    idle_pct  = 80;
                    stall_pct = 0;
                end
                2:
                begin
                    program_regs(1023, 0, 0, 0, 0, 0);
                    idle_pct  = 0;
                    stall_pct = 80;
                end
                3:
                begin
                    program_regs(1, 255, 100, 200, 1023, 1023);
                    idle_pct  = 28;
                    stall_pct = 28;
                    // tolerance saturating at both rails, zero and negative divisors
                    send_item(ACT_RECAL, 0, 1022);
                    send_item(ACT_READ_X, 100, 0);
                    send_item(ACT_READ_Y, 0, 1000);
                    send_item(ACT_READ_Y, 0, 0);
                    send_item(ACT_DPAD, 1023, 1022);
                end
                4:
                begin
                    program_regs($urandom_range(1023, 1), $urandom_range(255),
                                 $urandom_range(100), $urandom_range(200),
                                 $urandom_range(1023), $urandom_range(1023));
                    idle_pct  = 0;
                    stall_pct = 0;
                    hold_requests++;
                end
                default:
                begin
                    program_regs($urandom_range(1023, 1), $urandom_range(255),
                                 $urandom_range(100), $urandom_range(200),
                                 $urandom_range(1023), $urandom_range(1023));
                    idle_pct  = 28;
                    stall_pct = 28;
                end
            endcase
            run_random(RANDOM_ITEMS);
            settle();
        end

        if (results.pending_results.size() != 0)
        begin
            results.failures++;
            $display("%0d expected results never came out", results.pending_results.size());
        end
        $display("covered %0d recalibrations, %0d x reads, %0d y reads, %0d d-pad reads",
                 results.action_count[ACT_RECAL], results.action_count[ACT_READ_X],
                 results.action_count[ACT_READ_Y], results.action_count[ACT_DPAD]);
        $display("across %0d register settings: %0d results checked, %0d failures",
                 settings, results.checked, results.failures);
        if (results.failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
